/* hw/rtl/fsrst_pkg.sv */
// fsrst_pkg: sizes, codes and shared types of the fixed-slot row set table.
// No dependencies; imported by every module of the block except fsrst_ram.
package fsrst_pkg;

  // Store geometry
  localparam int MAX_ROWS    = 256;
  localparam int MAX_SLOTS   = 8;
  localparam int COL_BITS    = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);

  // The store is kept as blocks of eight slots, one block per memory word
  localparam int BLK_SLOTS   = 8;
  localparam int SEL_W       = $clog2(BLK_SLOTS);
  localparam int NUM_BLKS    = STORE_DEPTH / BLK_SLOTS;
  localparam int BLK_W       = ADDR_W - SEL_W;

  // Field widths
  localparam int ACT_W       = 2;
  localparam int IN_ROW_W    = 16;
  localparam int IN_COL_W    = 16;
  localparam int IDX_W       = 11;
  localparam int ST_W        = 3;
  localparam int ROWCNT_W    = 9;
  localparam int SPR_W       = 4;

  // Configuration port
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOTS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYM       = 2'd2;

  // Actions
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result status
  localparam logic [ST_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_ROW_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_ROW_FULL  = 3'd4;

  typedef struct packed {
    logic                vld;
    logic [COL_BITS-1:0] col;
  } ent_t;

  typedef ent_t [BLK_SLOTS-1:0] blk_t;

  typedef struct packed {
    logic [ROWCNT_W-1:0] rows;  // rows in use, clamped
    logic [SPR_W-1:0]    spr;   // slots per row, clamped
    logic                sym;
    logic                clr;   // geometry written: empty the store
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic rd;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic chk_done;
    logic scan_done;
    logic scan_next;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_SCAN,
    S_FINISH
  } ctrl_state_e;

endpackage

/* hw/rtl/fsrst_ram.sv */
// fsrst_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fsrst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fsrst_regs.sv */
// fsrst_regs: configuration registers behind the APB-style port.
// Depends on fsrst_pkg.
module fsrst_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsrst_pkg::PADDR_W-1:0]  paddr,
  input  logic [fsrst_pkg::PDATA_W-1:0]  pwdata,
  output logic [fsrst_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output fsrst_pkg::cfg_t                cfg_o
);
  import fsrst_pkg::*;

  logic [ROWCNT_W-1:0]  row_count_q, row_count_d;
  logic [SPR_W-1:0]     spr_q, spr_d;
  logic                 sym_q, sym_d;
  logic                 wr;
  logic                 clr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    row_count_d = row_count_q;
    spr_d       = spr_q;
    sym_d       = sym_q;
    clr         = 1'b0;
    if (wr) begin
      unique case (reg_idx)
        REG_ROW_COUNT: begin
          row_count_d = pwdata[ROWCNT_W-1:0];
          clr         = 1'b1;
        end
        REG_SLOTS: begin
          spr_d = pwdata[SPR_W-1:0];
          clr   = 1'b1;
        end
        REG_SYM: begin
          sym_d = pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      spr_q       <= SPR_W'(4);
      sym_q       <= 1'b0;
    end else begin
      row_count_q <= row_count_d;
      spr_q       <= spr_d;
      sym_q       <= sym_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count_q);
      REG_SLOTS:     prdata = PDATA_W'(spr_q);
      REG_SYM:       prdata = PDATA_W'(sym_q);
      default:       prdata = '0;
    endcase
  end

  // Clamp geometry to what the store holds
  always_comb begin
    cfg_o.rows = (row_count_q > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : row_count_q;
    if (spr_q == '0) begin
      cfg_o.spr = SPR_W'(1);
    end else if (spr_q > SPR_W'(MAX_SLOTS)) begin
      cfg_o.spr = SPR_W'(MAX_SLOTS);
    end else begin
      cfg_o.spr = spr_q;
    end
    cfg_o.sym = sym_q;
    cfg_o.clr = clr;
  end

endmodule

/* hw/rtl/fsrst_ctrl.sv */
// fsrst_ctrl: sequencer for one table operation (check, block read, slot scan, result).
// Depends on fsrst_pkg.
module fsrst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fsrst_pkg::dp_sts_t sts_i,
  output fsrst_pkg::dp_cmd_t cmd_o
);
  import fsrst_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.chk_done ? S_FINISH : S_ISSUE;
      end
      S_ISSUE: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end else if (sts_i.scan_next) begin
          state_d = S_ISSUE;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_CHECK:  cmd_o.check    = 1'b1;
      S_ISSUE:  cmd_o.rd       = 1'b1;
      S_SCAN:   cmd_o.scan     = 1'b1;
      S_FINISH: cmd_o.load_out = sts_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/fsrst_dp.sv */
// fsrst_dp: operand registers, slot store with block valid bits, scan logic, result register.
// Depends on fsrst_pkg and fsrst_ram.
module fsrst_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsrst_pkg::cfg_t               cfg_i,
  input  fsrst_pkg::dp_cmd_t            cmd_i,
  output fsrst_pkg::dp_sts_t            sts_o,
  input  logic [fsrst_pkg::ACT_W-1:0]    action_i,
  input  logic [fsrst_pkg::IN_ROW_W-1:0] row_i,
  input  logic [fsrst_pkg::IN_COL_W-1:0] col_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [fsrst_pkg::IDX_W-1:0]    slot_index_o,
  output logic [fsrst_pkg::ST_W-1:0]     status_o
);
  import fsrst_pkg::*;

  logic [ACT_W-1:0]       act_q;
  logic [IN_ROW_W-1:0]    row_q;
  logic [COL_BITS-1:0]    col_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [SPR_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       res_idx_q;
  logic [ST_W-1:0]        res_st_q;
  logic [NUM_BLKS-1:0]    blk_vld_q;
  logic                   out_vld_q;
  logic [IDX_W-1:0]       out_idx_q;
  logic [ST_W-1:0]        out_st_q;

  logic                   swap;
  logic [IN_ROW_W-1:0]    cap_row;
  logic [IN_COL_W-1:0]    cap_col;
  logic                   in_range;
  logic                   is_push;
  logic [ROW_W+SPR_W-1:0] prod;
  logic [ST_W-1:0]        chk_st;

  logic [$bits(blk_t)-1:0] ram_rdata;
  blk_t                   blk_rd;
  blk_t                   blk_wr;
  logic [SEL_W-1:0]       sel;
  logic [BLK_W-1:0]       blk_idx;
  logic                   blk_ok;
  ent_t                   ent;
  logic                   ent_vld;
  logic                   hit;
  logic [SPR_W-1:0]       cnt_nx;
  logic                   last;
  logic                   scan_done;
  logic                   do_ins;
  logic [ST_W-1:0]        scan_st;
  logic [IDX_W-1:0]       scan_idx;
  logic                   clr_all;

  // Symmetric mode: smaller value becomes the row
  assign swap    = cfg_i.sym && (col_i < row_i);
  assign cap_row = swap ? col_i : row_i;
  assign cap_col = swap ? row_i : col_i;

  assign is_push  = (act_q == ACT_PUSH);
  assign in_range = row_q < IN_ROW_W'(cfg_i.rows);
  assign prod     = row_q[ROW_W-1:0] * cfg_i.spr;

  always_comb begin
    case (act_q)
      ACT_CLEAR: chk_st = ST_FOUND;
      ACT_PUSH:  chk_st = ST_ROW_RANGE;
      default:   chk_st = ST_NOT_FOUND;
    endcase
  end

  assign clr_all = cfg_i.clr || (cmd_i.check && act_q == ACT_CLEAR);

  // Slot scan over the word read for the current block
  assign blk_rd   = blk_t'(ram_rdata);
  assign sel      = addr_q[SEL_W-1:0];
  assign blk_idx  = addr_q[ADDR_W-1:SEL_W];
  assign blk_ok   = blk_vld_q[blk_idx];
  assign ent      = blk_rd[sel];
  assign ent_vld  = blk_ok && ent.vld;
  assign hit      = ent_vld && (ent.col == col_q);
  assign cnt_nx   = cnt_q + SPR_W'(1);
  assign last     = (cnt_nx == cfg_i.spr);
  assign scan_done = hit || !ent_vld || last;
  assign do_ins   = cmd_i.scan && !ent_vld && is_push;

  always_comb begin
    scan_idx = '0;
    if (hit) begin
      scan_st  = ST_FOUND;
      scan_idx = IDX_W'(addr_q);
    end else if (!ent_vld) begin
      scan_st  = is_push ? ST_INSERTED : ST_NOT_FOUND;
      scan_idx = is_push ? IDX_W'(addr_q) : '0;
    end else begin
      scan_st  = is_push ? ST_ROW_FULL : ST_NOT_FOUND;
    end
  end

  // Rewrite the block: drop stale slots of an invalid block, fill the chosen slot
  always_comb begin
    for (int e = 0; e < BLK_SLOTS; e++) begin
      blk_wr[e].vld = blk_ok && blk_rd[e].vld;
      blk_wr[e].col = blk_rd[e].col;
    end
    blk_wr[sel].vld = 1'b1;
    blk_wr[sel].col = col_q;
  end

  fsrst_ram #(
    .WIDTH ($bits(blk_t)),
    .DEPTH (NUM_BLKS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_ins),
    .waddr_i (blk_idx),
    .wdata_i (blk_wr),
    .re_i    (cmd_i.rd),
    .raddr_i (blk_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      row_q <= cap_row;
      col_q <= cap_col[COL_BITS-1:0];
    end
    if (cmd_i.check) begin
      addr_q    <= prod[ADDR_W-1:0];
      cnt_q     <= '0;
      res_st_q  <= chk_st;
      res_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      res_st_q  <= scan_st;
      res_idx_q <= scan_idx;
      if (!scan_done) begin
        addr_q <= addr_q + ADDR_W'(1);
        cnt_q  <= cnt_nx;
      end
    end
    if (cmd_i.load_out) begin
      out_idx_q <= res_idx_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (clr_all) begin
        blk_vld_q <= '0;
      end else if (do_ins) begin
        blk_vld_q[blk_idx] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.chk_done  = !(in_range && (act_q == ACT_LOOKUP || act_q == ACT_PUSH));
    sts_o.scan_done = scan_done;
    sts_o.scan_next = (sel == SEL_W'(BLK_SLOTS - 1));
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o  = out_vld_q;
  assign slot_index_o = out_idx_q;
  assign status_o     = out_st_q;

endmodule

/* hw/rtl/fixed_slot_row_set_table_core.sv */
// fixed_slot_row_set_table_core: top level of the fixed-slot row set table.
// Depends on fsrst_pkg, fsrst_regs, fsrst_ctrl, fsrst_dp (and fsrst_ram below it).
//
//   channel  direction  handshake                 words
//   in       input      in_valid_i / in_ready_o   action_i, row_i, col_i
//   out      output     out_valid_o / out_ready_i slot_index_o, status_o
//   cfg      input      psel, penable, pwrite     paddr, pwdata -> prdata, pready
//
// One word at a time: accept, check, then for each block of eight slots a read of the block,
// then a scan of its slots one at a time, then a load of the result register.
// Clear, unused action and out-of-range rows go from the check straight to the result.
// Reset, a clear action and a geometry write empty the store at once via per-block
// valid bits. A stalled result sits in the output register; the next word is taken.
module fixed_slot_row_set_table_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fsrst_pkg::ACT_W-1:0]     action_i,
  input  logic [fsrst_pkg::IN_ROW_W-1:0]  row_i,
  input  logic [fsrst_pkg::IN_COL_W-1:0]  col_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fsrst_pkg::IDX_W-1:0]     slot_index_o,
  output logic [fsrst_pkg::ST_W-1:0]      status_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsrst_pkg::PADDR_W-1:0]   paddr,
  input  logic [fsrst_pkg::PDATA_W-1:0]   pwdata,
  output logic [fsrst_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import fsrst_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  fsrst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsrst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsrst_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .slot_index_o (slot_index_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  // One word in flight: an accepted word blocks the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while a word is in flight");

  // The input only closes because a word was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input closed without an accepted word");

  // Index is zero unless a slot was found or filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_FOUND && status_o != ST_INSERTED) |->
      (slot_index_o == '0))
    else $error("non-zero index with a miss status");
`endif

endmodule
